// ===== design/lwct_pkg.sv =====
// ============================================================================
// lwct_pkg: shared types and constants of the linear world coordinate transform
// Item formats, register map and the fixed-point widths of the datapath.
// ============================================================================
package lwct_pkg;

    // Fixed point formats
    localparam int MATRIX_FRAC_BITS = 48;           // matrix entries Q15.48
    localparam int COORD_W          = 64;           // coordinates Q31.32
    localparam int MAT_W            = 64;

    // Configuration port
    localparam int DATA_W   = 64;
    localparam int NUM_REGS = 8;
    localparam int ADDR_W   = $clog2(NUM_REGS * 8);

    typedef enum logic [2:0] {
        REG_M11   = 3'd0,
        REG_M12   = 3'd1,
        REG_M21   = 3'd2,
        REG_M22   = 3'd3,
        REG_RPIX0 = 3'd4,
        REG_RPIX1 = 3'd5,
        REG_RWLD0 = 3'd6,
        REG_RWLD1 = 3'd7
    } reg_idx_t;

    // Direction codes
    localparam logic KIND_PIX2WLD = 1'b0;
    localparam logic KIND_WLD2PIX = 1'b1;

    // Datapath widths
    localparam int DIFF_W    = COORD_W + 1;                   // coord minus reference
    localparam int HALF_W    = 33;                            // multiplier operand
    localparam int PP_W      = 2 * HALF_W;                    // partial product
    localparam int PROD_W    = MAT_W + DIFF_W;                // full product
    localparam int SUM_W     = PROD_W + 1;                    // sum of two products
    localparam int NUM_W     = SUM_W + MATRIX_FRAC_BITS + 1;  // division numerator
    localparam int ADET_W    = 2 * MAT_W;                     // |determinant|
    localparam int DIV_W     = ADET_W + 1;                    // divisor
    localparam int QUO_W     = COORD_W + 1;                   // quotient bits kept
    localparam int OUT_SUM_W = COORD_W + 3;
    localparam int ACC_W     = 180;                           // setup accumulator

    localparam logic [MAT_W-1:0]  M_ONE      = MAT_W'(1) << MATRIX_FRAC_BITS;
    localparam logic [NUM_W-1:0]  ROUND_HALF = NUM_W'(1) << (MATRIX_FRAC_BITS - 1);
    localparam logic [DIV_W-1:0]  P2W_DIV    = DIV_W'(1) << MATRIX_FRAC_BITS;
    localparam logic [49:0]       PIVOT_RECIP = 50'd1000000000000000;  // 1 / 1e-15

    localparam logic signed [COORD_W-1:0] SAT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] SAT_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef struct packed {
        logic                      kind;
        logic signed [COORD_W-1:0] coord_first;
        logic signed [COORD_W-1:0] coord_second;
    } coord_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] result_first;
        logic signed [COORD_W-1:0] result_second;
        logic                      singular;
    } result_t;

endpackage

// ===== design/linear_world_coordinate_transform.sv =====
// ============================================================================
// linear_world_coordinate_transform
// Two-axis linear pixel/world transform with a deep pipeline.
// ============================================================================
// Usage:
// - coord channel carries one item per accepted cycle: a direction (kind) and a
//   coordinate pair. kind 0 maps pixel to world, kind 1 world to pixel.
// - result channel returns one item per input item, in order.
// - Throughput is one item per clock while coord_stall is low. The pipeline has
//   74 register stages: seven arithmetic stages (offset, 33x33 partial products,
//   two product adds, combine, numerator, magnitude), a divider entry stage with
//   the overflow check, 65 one-bit restoring divider stages, then the output
//   register.
// - The matrix derived values (determinant, pivot test) come from a setup
//   sequencer with one shared 33x33 multiplier; it runs after reset and after
//   every register write, and coord_stall stays high meanwhile.
// - When result_stall holds a waiting result, the whole pipeline freezes and
//   coord_stall rises; nothing is dropped or repeated.
// - The APB port (64-bit data, register i at byte 8*i) reads back registers;
//   pready is always high.
// ============================================================================
module linear_world_coordinate_transform (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lwct_pkg::ADDR_W-1:0]     paddr,
    input  logic [lwct_pkg::DATA_W-1:0]     pwdata,
    output logic [lwct_pkg::DATA_W-1:0]     prdata,
    output logic                            pready,
    input  logic                            coord_valid,
    output logic                            coord_stall,
    input  lwct_pkg::coord_t                coord,
    output logic                            result_valid,
    input  logic                            result_stall,
    output lwct_pkg::result_t               result
);
    import lwct_pkg::*;

    // setup sequencer schedule
    localparam logic [4:0] SEQ_DET_LAST  = 5'd7;
    localparam logic [4:0] SEQ_DET_TAKE  = 5'd9;
    localparam logic [4:0] SEQ_SCL_FIRST = 5'd10;
    localparam logic [4:0] SEQ_SCL_LAST  = 5'd17;
    localparam logic [4:0] SEQ_DONE      = 5'd19;

    function automatic logic [DIV_W-1:0] divisor_of(input logic kind,
                                                    input logic [ADET_W-1:0] absd);
        return (kind == KIND_WLD2PIX) ? {absd, 1'b0} : P2W_DIV;
    endfunction

    // ------------------------------------------------------------------------
    // Register file
    // ------------------------------------------------------------------------
    logic [DATA_W-1:0] cfg_reg [NUM_REGS];
    logic              cfg_wr;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = cfg_reg[paddr[ADDR_W-1:3]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                cfg_reg[i] <= '0;
            end
            cfg_reg[REG_M11] <= M_ONE;
            cfg_reg[REG_M22] <= M_ONE;
        end
        else if (cfg_wr)
        begin
            cfg_reg[paddr[ADDR_W-1:3]] <= pwdata;
        end
    end

    logic signed [MAT_W-1:0]   mat_a, mat_b, mat_c, mat_d;
    logic signed [COORD_W-1:0] rpix0, rpix1, rwld0, rwld1;

    assign mat_a = cfg_reg[REG_M11];
    assign mat_b = cfg_reg[REG_M12];
    assign mat_c = cfg_reg[REG_M21];
    assign mat_d = cfg_reg[REG_M22];
    assign rpix0 = cfg_reg[REG_RPIX0];
    assign rpix1 = cfg_reg[REG_RPIX1];
    assign rwld0 = cfg_reg[REG_RWLD0];
    assign rwld1 = cfg_reg[REG_RWLD1];

    // ------------------------------------------------------------------------
    // Setup sequencer: det = A*D - B*C, then |det| * 1e15 for the pivot test
    // ------------------------------------------------------------------------
    logic                     busy_reg;
    logic [4:0]               step_reg;
    logic [ACC_W-1:0]         acc_reg;
    logic signed [PP_W-1:0]   seq_pp_reg;
    logic [2:0]               seq_shift_reg;
    logic                     seq_sub_reg;
    logic                     seq_en_reg;
    logic                     det_neg_reg;
    logic [ADET_W-1:0]        abs_det_reg;
    logic                     sing_reg;

    logic signed [HALF_W-1:0] mul_a, mul_b;
    logic [2:0]               mul_shift;
    logic                     mul_sub;
    logic                     mul_en;
    logic signed [PP_W-1:0]   seq_pp_next;
    logic [ACC_W-1:0]         seq_pp_ext;
    logic [ACC_W-1:0]         acc_next;
    logic [4:0]               scl_idx;
    logic [PROD_W-1:0]        seq_det;
    logic [ADET_W-1:0]        abs_det_next;
    logic [MAT_W-1:0]         abs_a, abs_c, pivot0;
    logic                     sing_next;

    // operand select for the shared multiplier
    always_comb
    begin
        logic [MAT_W-1:0] x;
        logic [MAT_W-1:0] y;
        x         = step_reg[2] ? mat_b : mat_a;
        y         = step_reg[2] ? mat_c : mat_d;
        scl_idx   = step_reg - SEQ_SCL_FIRST;
        mul_en    = 1'b0;
        mul_sub   = 1'b0;
        mul_shift = '0;
        mul_a     = '0;
        mul_b     = '0;
        if (busy_reg && step_reg <= SEQ_DET_LAST)
        begin
            mul_en    = 1'b1;
            mul_sub   = step_reg[2];
            mul_a     = step_reg[1] ? {x[63], x[63:32]} : {1'b0, x[31:0]};
            mul_b     = step_reg[0] ? {y[63], y[63:32]} : {1'b0, y[31:0]};
            mul_shift = {2'b0, step_reg[1]} + {2'b0, step_reg[0]};
        end
        else if (busy_reg && step_reg >= SEQ_SCL_FIRST && step_reg <= SEQ_SCL_LAST)
        begin
            mul_en    = 1'b1;
            mul_a     = {1'b0, abs_det_reg[{scl_idx[2:1], 5'b0} +: 32]};
            mul_b     = scl_idx[0] ? {15'b0, PIVOT_RECIP[49:32]}
                                   : {1'b0, PIVOT_RECIP[31:0]};
            mul_shift = {1'b0, scl_idx[2:1]} + {2'b0, scl_idx[0]};
        end
    end

    assign seq_pp_next  = mul_a * mul_b;
    assign seq_pp_ext   = ACC_W'(seq_pp_reg) << {seq_shift_reg, 5'b0};
    assign acc_next     = seq_sub_reg ? (acc_reg - seq_pp_ext) : (acc_reg + seq_pp_ext);
    assign seq_det      = acc_reg[PROD_W-1:0];
    assign abs_det_next = seq_det[PROD_W-1] ? ADET_W'(~seq_det + PROD_W'(1))
                                            : seq_det[ADET_W-1:0];

    // pivot test: first pivot max(|A|,|C|), second |det| / first pivot
    assign abs_a     = mat_a[MAT_W-1] ? (~mat_a + MAT_W'(1)) : mat_a;
    assign abs_c     = mat_c[MAT_W-1] ? (~mat_c + MAT_W'(1)) : mat_c;
    assign pivot0    = (abs_c > abs_a) ? abs_c : abs_a;
    assign sing_next = (pivot0 == '0) ||
                       (acc_reg < ACC_W'({pivot0, {MATRIX_FRAC_BITS{1'b0}}}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b1;
            step_reg   <= '0;
            acc_reg    <= '0;
            seq_en_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            busy_reg   <= 1'b1;
            step_reg   <= '0;
            acc_reg    <= '0;
            seq_en_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            seq_en_reg <= mul_en;
            if (step_reg == SEQ_DONE)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                step_reg <= step_reg + 5'd1;
            end
            if (step_reg == SEQ_DET_TAKE)
            begin
                acc_reg <= '0;
            end
            else if (seq_en_reg)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    // sequencer payload
    always_ff @(posedge clk)
    begin
        seq_pp_reg    <= seq_pp_next;
        seq_shift_reg <= mul_shift;
        seq_sub_reg   <= mul_sub;
        if (busy_reg && step_reg == SEQ_DET_TAKE)
        begin
            det_neg_reg <= seq_det[PROD_W-1];
            abs_det_reg <= abs_det_next;
        end
        if (busy_reg && step_reg == SEQ_DONE)
        begin
            sing_reg <= sing_next;
        end
    end

    // ------------------------------------------------------------------------
    // Pipeline control: one global advance, frozen only by a held result
    // ------------------------------------------------------------------------
    logic result_valid_reg;
    logic adv;

    assign adv         = !result_valid_reg || !result_stall;
    assign coord_stall = busy_reg || !adv;

    // ------------------------------------------------------------------------
    // Stage 1: subtract the reference point
    // ------------------------------------------------------------------------
    logic                     s1_valid_reg, s1_kind_reg;
    logic signed [DIFF_W-1:0] s1_u0_reg, s1_u1_reg;
    logic signed [DIFF_W-1:0] s1_u0_next, s1_u1_next;
    logic signed [COORD_W-1:0] in_base0, in_base1;

    assign in_base0   = (coord.kind == KIND_WLD2PIX) ? rwld0 : rpix0;
    assign in_base1   = (coord.kind == KIND_WLD2PIX) ? rwld1 : rpix1;
    assign s1_u0_next = DIFF_W'(coord.coord_first)  - DIFF_W'(in_base0);
    assign s1_u1_next = DIFF_W'(coord.coord_second) - DIFF_W'(in_base1);

    // ------------------------------------------------------------------------
    // Stage 2: 33x33 partial products of the four matrix products
    // ------------------------------------------------------------------------
    logic                     s2_valid_reg, s2_kind_reg;
    logic signed [PP_W-1:0]   s2_hh_reg [4];
    logic signed [PP_W-1:0]   s2_hl_reg [4];
    logic signed [PP_W-1:0]   s2_lh_reg [4];
    logic signed [PP_W-1:0]   s2_ll_reg [4];
    logic signed [PP_W-1:0]   s2_hh_next [4];
    logic signed [PP_W-1:0]   s2_hl_next [4];
    logic signed [PP_W-1:0]   s2_lh_next [4];
    logic signed [PP_W-1:0]   s2_ll_next [4];
    logic signed [MAT_W-1:0]  mop [4];
    logic signed [DIFF_W-1:0] uop [4];

    always_comb
    begin
        logic signed [HALF_W-1:0] ahi, alo, uhi, ulo;
        mop[0] = (s1_kind_reg == KIND_WLD2PIX) ? mat_d : mat_a;
        uop[0] = s1_u0_reg;
        mop[1] = mat_b;
        uop[1] = s1_u1_reg;
        mop[2] = (s1_kind_reg == KIND_WLD2PIX) ? mat_a : mat_d;
        uop[2] = s1_u1_reg;
        mop[3] = mat_c;
        uop[3] = s1_u0_reg;
        for (int j = 0; j < 4; j++)
        begin
            ahi = {mop[j][MAT_W-1], mop[j][MAT_W-1:32]};
            alo = {1'b0, mop[j][31:0]};
            uhi = uop[j][DIFF_W-1:32];
            ulo = {1'b0, uop[j][31:0]};
            s2_hh_next[j] = ahi * uhi;
            s2_hl_next[j] = ahi * ulo;
            s2_lh_next[j] = alo * uhi;
            s2_ll_next[j] = alo * ulo;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 3: merge the outer terms, add the cross terms
    // Stage 4: full products
    // ------------------------------------------------------------------------
    logic                     s3_valid_reg, s3_kind_reg;
    logic signed [PROD_W-1:0] s3_hhll_reg [4];
    logic signed [PP_W-1:0]   s3_mid_reg [4];
    logic                     s4_valid_reg, s4_kind_reg;
    logic signed [PROD_W-1:0] s4_prod_reg [4];

    // ------------------------------------------------------------------------
    // Stage 5: combine products; world to pixel folds the determinant sign
    // ------------------------------------------------------------------------
    logic                     s5_valid_reg, s5_kind_reg;
    logic signed [SUM_W-1:0]  s5_v_reg [2];
    logic signed [SUM_W-1:0]  s5_v_next [2];
    logic signed [SUM_W-1:0]  m0, m1, m2, m3;

    assign m0 = SUM_W'(s4_prod_reg[0]);
    assign m1 = SUM_W'(s4_prod_reg[1]);
    assign m2 = SUM_W'(s4_prod_reg[2]);
    assign m3 = SUM_W'(s4_prod_reg[3]);

    always_comb
    begin
        if (s4_kind_reg == KIND_PIX2WLD)
        begin
            s5_v_next[0] = m0 + m1;
            s5_v_next[1] = m3 + m2;
        end
        else if (det_neg_reg)
        begin
            s5_v_next[0] = m1 - m0;
            s5_v_next[1] = m3 - m2;
        end
        else
        begin
            s5_v_next[0] = m0 - m1;
            s5_v_next[1] = m2 - m3;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 6: numerator, floor(T / divisor) gives the rounded result
    // ------------------------------------------------------------------------
    logic                     s6_valid_reg, s6_kind_reg;
    logic signed [NUM_W-1:0]  s6_t_reg [2];
    logic signed [NUM_W-1:0]  s6_t_next [2];

    always_comb
    begin
        for (int ax = 0; ax < 2; ax++)
        begin
            if (s5_kind_reg == KIND_WLD2PIX)
            begin
                s6_t_next[ax] = (NUM_W'(s5_v_reg[ax]) <<< (MATRIX_FRAC_BITS + 1))
                              + NUM_W'({1'b0, abs_det_reg});
            end
            else
            begin
                s6_t_next[ax] = NUM_W'(s5_v_reg[ax]) + ROUND_HALF;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage 7: magnitude for floor division of a negative numerator
    // ------------------------------------------------------------------------
    logic                     s7_valid_reg, s7_kind_reg;
    logic [NUM_W-1:0]         s7_tm_reg [2];
    logic                     s7_neg_reg [2];
    logic [NUM_W-1:0]         s7_tm_next [2];
    logic [DIV_W-1:0]         s6_div;

    assign s6_div = divisor_of(s6_kind_reg, abs_det_reg);

    always_comb
    begin
        for (int ax = 0; ax < 2; ax++)
        begin
            s7_tm_next[ax] = s6_t_reg[ax][NUM_W-1] ? (~s6_t_reg[ax] + NUM_W'(s6_div))
                                                   : s6_t_reg[ax];
        end
    end

    // ------------------------------------------------------------------------
    // Divider: entry stage with overflow check, then one quotient bit a stage
    // ------------------------------------------------------------------------
    logic             dv_valid_reg [QUO_W+1];
    logic             dv_kind_reg  [QUO_W+1];
    logic             dv_neg_reg   [QUO_W+1][2];
    logic             dv_ovf_reg   [QUO_W+1][2];
    logic [DIV_W-1:0] dv_rem_reg   [QUO_W+1][2];
    logic [QUO_W-1:0] dv_lq_reg    [QUO_W+1][2];
    logic [DIV_W-1:0] dv_rem_next  [QUO_W+1][2];
    logic [QUO_W-1:0] dv_lq_next   [QUO_W+1][2];
    logic             dv0_ovf_next [2];
    logic [DIV_W-1:0] s7_div;

    assign s7_div = divisor_of(s7_kind_reg, abs_det_reg);

    always_comb
    begin
        logic [DIV_W-1:0] dd;
        logic [DIV_W:0]   rs;
        logic             ge;
        for (int ax = 0; ax < 2; ax++)
        begin
            dv0_ovf_next[ax]   = (DIV_W+QUO_W)'(s7_tm_reg[ax]) >= {s7_div, {QUO_W{1'b0}}};
            dv_rem_next[0][ax] = DIV_W'(s7_tm_reg[ax][NUM_W-1:QUO_W]);
            dv_lq_next[0][ax]  = s7_tm_reg[ax][QUO_W-1:0];
        end
        for (int i = 1; i <= QUO_W; i++)
        begin
            dd = divisor_of(dv_kind_reg[i-1], abs_det_reg);
            for (int ax = 0; ax < 2; ax++)
            begin
                rs = {dv_rem_reg[i-1][ax], dv_lq_reg[i-1][ax][QUO_W-1]};
                ge = rs >= {1'b0, dd};
                dv_rem_next[i][ax] = ge ? DIV_W'(rs - {1'b0, dd}) : rs[DIV_W-1:0];
                dv_lq_next[i][ax]  = {dv_lq_reg[i-1][ax][QUO_W-2:0], ge};
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output: add the reference, saturate, singular override
    // ------------------------------------------------------------------------
    result_t result_reg;
    result_t result_next;

    always_comb
    begin
        logic signed [COORD_W-1:0]   base [2];
        logic signed [OUT_SUM_W-1:0] sum;
        logic signed [COORD_W-1:0]   res [2];
        logic                        last_kind;
        last_kind = dv_kind_reg[QUO_W];
        base[0]   = (last_kind == KIND_WLD2PIX) ? rpix0 : rwld0;
        base[1]   = (last_kind == KIND_WLD2PIX) ? rpix1 : rwld1;
        for (int ax = 0; ax < 2; ax++)
        begin
            if (dv_neg_reg[QUO_W][ax])
            begin
                sum = OUT_SUM_W'(base[ax]) - OUT_SUM_W'(dv_lq_reg[QUO_W][ax]);
            end
            else
            begin
                sum = OUT_SUM_W'(base[ax]) + OUT_SUM_W'(dv_lq_reg[QUO_W][ax]);
            end
            if (dv_ovf_reg[QUO_W][ax])
            begin
                res[ax] = dv_neg_reg[QUO_W][ax] ? SAT_MIN : SAT_MAX;
            end
            else if (sum[OUT_SUM_W-1:COORD_W-1] != {(OUT_SUM_W-COORD_W+1){sum[OUT_SUM_W-1]}})
            begin
                res[ax] = sum[OUT_SUM_W-1] ? SAT_MIN : SAT_MAX;
            end
            else
            begin
                res[ax] = sum[COORD_W-1:0];
            end
        end
        if (last_kind == KIND_WLD2PIX && sing_reg)
        begin
            result_next.result_first  = '0;
            result_next.result_second = '0;
            result_next.singular      = 1'b1;
        end
        else
        begin
            result_next.result_first  = res[0];
            result_next.result_second = res[1];
            result_next.singular      = 1'b0;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ------------------------------------------------------------------------
    // Valid chain
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            s4_valid_reg     <= 1'b0;
            s5_valid_reg     <= 1'b0;
            s6_valid_reg     <= 1'b0;
            s7_valid_reg     <= 1'b0;
            for (int i = 0; i <= QUO_W; i++)
            begin
                dv_valid_reg[i] <= 1'b0;
            end
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg    <= coord_valid && !busy_reg;
            s2_valid_reg    <= s1_valid_reg;
            s3_valid_reg    <= s2_valid_reg;
            s4_valid_reg    <= s3_valid_reg;
            s5_valid_reg    <= s4_valid_reg;
            s6_valid_reg    <= s5_valid_reg;
            s7_valid_reg    <= s6_valid_reg;
            dv_valid_reg[0] <= s7_valid_reg;
            for (int i = 1; i <= QUO_W; i++)
            begin
                dv_valid_reg[i] <= dv_valid_reg[i-1];
            end
            result_valid_reg <= dv_valid_reg[QUO_W];
        end
    end

    // ------------------------------------------------------------------------
    // Pipeline payload
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_kind_reg <= coord.kind;
            s1_u0_reg   <= s1_u0_next;
            s1_u1_reg   <= s1_u1_next;

            s2_kind_reg <= s1_kind_reg;
            s3_kind_reg <= s2_kind_reg;
            s4_kind_reg <= s3_kind_reg;
            for (int j = 0; j < 4; j++)
            begin
                s2_hh_reg[j]   <= s2_hh_next[j];
                s2_hl_reg[j]   <= s2_hl_next[j];
                s2_lh_reg[j]   <= s2_lh_next[j];
                s2_ll_reg[j]   <= s2_ll_next[j];
                s3_hhll_reg[j] <= {s2_hh_reg[j][PP_W-2:0], s2_ll_reg[j][63:0]};
                s3_mid_reg[j]  <= s2_hl_reg[j] + s2_lh_reg[j];
                s4_prod_reg[j] <= s3_hhll_reg[j] + (PROD_W'(s3_mid_reg[j]) <<< 32);
            end

            s5_kind_reg <= s4_kind_reg;
            s6_kind_reg <= s5_kind_reg;
            s7_kind_reg <= s6_kind_reg;
            dv_kind_reg[0] <= s7_kind_reg;
            for (int ax = 0; ax < 2; ax++)
            begin
                s5_v_reg[ax]       <= s5_v_next[ax];
                s6_t_reg[ax]       <= s6_t_next[ax];
                s7_tm_reg[ax]      <= s7_tm_next[ax];
                s7_neg_reg[ax]     <= s6_t_reg[ax][NUM_W-1];
                dv_neg_reg[0][ax]  <= s7_neg_reg[ax];
                dv_ovf_reg[0][ax]  <= dv0_ovf_next[ax];
            end
            for (int i = 0; i <= QUO_W; i++)
            begin
                for (int ax = 0; ax < 2; ax++)
                begin
                    dv_rem_reg[i][ax] <= dv_rem_next[i][ax];
                    dv_lq_reg[i][ax]  <= dv_lq_next[i][ax];
                end
            end
            for (int i = 1; i <= QUO_W; i++)
            begin
                dv_kind_reg[i] <= dv_kind_reg[i-1];
                for (int ax = 0; ax < 2; ax++)
                begin
                    dv_neg_reg[i][ax] <= dv_neg_reg[i-1][ax];
                    dv_ovf_reg[i][ax] <= dv_ovf_reg[i-1][ax];
                end
            end
            result_reg <= result_next;
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    // no item enters while derived matrix values are being rebuilt
    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> coord_stall)
        else $error("item accepted during setup");

    // a register write restarts setup from the first step
    a_write_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> (busy_reg && step_reg == '0))
        else $error("setup not restarted by register write");

    // an idle sequencer always sits on its final step
    a_idle_done: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (step_reg == SEQ_DONE))
        else $error("sequencer idle mid-schedule");

    // a singular result carries zero coordinates
    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.singular) |->
            (result.result_first == '0 && result.result_second == '0))
        else $error("singular result with nonzero coordinates");

endmodule

// ===== sim/linear_world_coordinate_transform_tb.sv =====
// ============================================================================
// linear_world_coordinate_transform_tb
// Drives coordinate items in both directions through several matrix and
// reference settings, and compares each result with an exact predictor
// built on 256-bit signed arithmetic.
// ============================================================================
module linear_world_coordinate_transform_tb;
    import lwct_pkg::*;

    typedef logic signed [255:0] wide_t;

    // Exact transform predictor with its own register copy
    class transform_scoreboard;
        logic signed [63:0] regs [NUM_REGS];
        result_t            pending [$];
        int                 errors;
        int                 checked;
        int                 singular_seen;

        function new();
            foreach (regs[i]) regs[i] = '0;
            regs[REG_M11] = M_ONE;
            regs[REG_M22] = M_ONE;
            errors = 0;
            checked = 0;
            singular_seen = 0;
        endfunction

        function wide_t wx(logic signed [63:0] v);
            wide_t r;
            r = v;
            return r;
        endfunction

        function wide_t mag(wide_t v);
            return v < 0 ? -v : v;
        endfunction

        function logic signed [63:0] clamp(wide_t v);
            if (v > wx(SAT_MAX)) return SAT_MAX;
            if (v < wx(SAT_MIN)) return SAT_MIN;
            return v[63:0];
        endfunction

        // nearest of n/d, ties toward plus infinity; d > 0
        function wide_t nearest_quotient(wide_t n, wide_t d);
            wide_t t, dd;
            t  = 2 * n + d;
            dd = 2 * d;
            if (t >= 0) return t / dd;
            return -((-t + dd - 1) / dd);
        endfunction

        function result_t transform(coord_t c);
            result_t r;
            wide_t a, b, cc, d, x0, x1, d0, d1, s0, s1, p0, det, n0, n1, thr;
            a  = wx(regs[REG_M11]);
            b  = wx(regs[REG_M12]);
            cc = wx(regs[REG_M21]);
            d  = wx(regs[REG_M22]);
            x0 = wx(c.coord_first);
            x1 = wx(c.coord_second);
            thr = 256'sd1000000000000000;
            r = '0;
            if (c.kind == KIND_PIX2WLD)
            begin
                d0 = x0 - wx(regs[REG_RPIX0]);
                d1 = x1 - wx(regs[REG_RPIX1]);
                s0 = (a * d0 + b * d1 + (wide_t'(1) <<< (MATRIX_FRAC_BITS - 1)))
                     >>> MATRIX_FRAC_BITS;
                s1 = (cc * d0 + d * d1 + (wide_t'(1) <<< (MATRIX_FRAC_BITS - 1)))
                     >>> MATRIX_FRAC_BITS;
                r.result_first  = clamp(wx(regs[REG_RWLD0]) + s0);
                r.result_second = clamp(wx(regs[REG_RWLD1]) + s1);
                return r;
            end
            // pivot tests of the elimination
            p0  = mag(cc) > mag(a) ? mag(cc) : mag(a);
            det = a * d - b * cc;
            if (p0 * thr < (wide_t'(1) <<< MATRIX_FRAC_BITS) ||
                mag(det) * thr < (p0 <<< MATRIX_FRAC_BITS))
            begin
                r.singular = 1'b1;
                return r;
            end
            d0 = x0 - wx(regs[REG_RWLD0]);
            d1 = x1 - wx(regs[REG_RWLD1]);
            n0 = (d * d0 - b * d1) <<< MATRIX_FRAC_BITS;
            n1 = (a * d1 - cc * d0) <<< MATRIX_FRAC_BITS;
            if (det < 0)
            begin
                det = -det;
                n0  = -n0;
                n1  = -n1;
            end
            r.result_first  = clamp(wx(regs[REG_RPIX0]) + nearest_quotient(n0, det));
            r.result_second = clamp(wx(regs[REG_RPIX1]) + nearest_quotient(n1, det));
            return r;
        endfunction

        function void note_input(coord_t c);
            pending.push_back(transform(c));
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (want.singular) singular_seen++;
            if (got.result_first !== want.result_first)
            begin
                $display("%0t: result_first expected %h got %h", $time,
                         want.result_first, got.result_first);
                errors++;
            end
            if (got.result_second !== want.result_second)
            begin
                $display("%0t: result_second expected %h got %h", $time,
                         want.result_second, got.result_second);
                errors++;
            end
            if (got.singular !== want.singular)
            begin
                $display("%0t: singular expected %b got %b", $time,
                         want.singular, got.singular);
                errors++;
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              coord_valid = 1'b0;
    logic              coord_stall;
    coord_t            coord = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    result_t           result;

    transform_scoreboard sb = new();
    logic                no_idle = 1'b0;
    int                  sent = 0;

    linear_world_coordinate_transform dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .coord_valid(coord_valid), .coord_stall(coord_stall), .coord(coord),
        .result_valid(result_valid), .result_stall(result_stall), .result(result)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // result side: random stalls
    always @(negedge clk)
        result_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 28);

    always @(posedge clk)
        if (rst_n && result_valid && !result_stall) sb.check_result(result);

    // mix of full-range, extreme and moderate values
    function automatic logic signed [63:0] pick_value();
        logic signed [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(5))
            0: v = SAT_MAX - $urandom_range(3);
            1: v = SAT_MIN + $urandom_range(3);
            2, 3: v = $signed(v[43:0]);
            4: v = $signed(v[53:0]);
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic signed [63:0] pick_entry();
        logic signed [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(4))
            0: v = $signed(v[50:0]);
            1: v = $signed(v[40:0]);
            2: v = $signed(v[52:0]);
            default: ;
        endcase
        return v;
    endfunction

    // setup and access phase, then the port goes idle before the task returns
    task automatic write_reg(reg_idx_t idx, logic signed [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx) << 3;
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.regs[idx] = val;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic load_matrix(logic signed [63:0] a, logic signed [63:0] b,
                               logic signed [63:0] c, logic signed [63:0] d);
        write_reg(REG_M11, a);
        write_reg(REG_M12, b);
        write_reg(REG_M21, c);
        write_reg(REG_M22, d);
    endtask

    task automatic load_refs();
        write_reg(REG_RPIX0, pick_value());
        write_reg(REG_RPIX1, pick_value());
        write_reg(REG_RWLD0, pick_value());
        write_reg(REG_RWLD1, pick_value());
    endtask

    // one item, with a possible gap before it
    task automatic send_item(logic kind, logic signed [63:0] c0, logic signed [63:0] c1);
        while (!no_idle && $urandom_range(99) < 28)
        begin
            coord_valid <= 1'b0;
            @(negedge clk);
        end
        coord_valid        <= 1'b1;
        coord.kind         <= kind;
        coord.coord_first  <= c0;
        coord.coord_second <= c1;
        do @(posedge clk); while (coord_stall);
        sb.note_input({kind, c0, c1});
        sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        coord_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic random_items(int n);
        repeat (n) send_item(1'($urandom_range(1)), pick_value(), pick_value());
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset identity, extremes in both directions
        send_item(KIND_PIX2WLD, 64'sd0, 64'sd0);
        send_item(KIND_WLD2PIX, 64'sd0, 64'sd0);
        send_item(KIND_PIX2WLD, SAT_MAX, SAT_MIN);
        send_item(KIND_WLD2PIX, SAT_MIN, SAT_MAX);
        send_item(KIND_PIX2WLD, -64'sd1, 64'sd1);
        send_item(KIND_WLD2PIX, -64'sd1, 64'sd1);
        drain();
        // scale up, shift references: saturation and rounding ties
        load_matrix(64'sh0004_0000_0000_0000, 64'sh0000_8000_0000_0000,
                    -64'sh0000_8000_0000_0000, 64'sh0000_8000_0000_0000);
        write_reg(REG_RPIX0, SAT_MAX);
        write_reg(REG_RPIX1, SAT_MIN);
        write_reg(REG_RWLD0, 64'sd12345);
        write_reg(REG_RWLD1, -64'sd999);
        send_item(KIND_PIX2WLD, SAT_MIN, SAT_MAX);
        send_item(KIND_WLD2PIX, SAT_MAX, SAT_MIN);
        send_item(KIND_PIX2WLD, 64'sd1, -64'sd1);
        send_item(KIND_WLD2PIX, 64'sd12346, -64'sd998);
        drain();
        // singular: zero first column, then zero determinant, then tiny pivot
        load_matrix(64'sd0, M_ONE, 64'sd0, M_ONE);
        send_item(KIND_WLD2PIX, 64'sd5, 64'sd7);
        send_item(KIND_PIX2WLD, 64'sd5, 64'sd7);
        drain();
        load_matrix(M_ONE, M_ONE, M_ONE, M_ONE);
        send_item(KIND_WLD2PIX, 64'sd5, 64'sd7);
        drain();
        load_matrix(64'sd1, 64'sd0, 64'sd0, 64'sd1);
        send_item(KIND_WLD2PIX, 64'sd5, -64'sd7);
        drain();
        // most negative and most positive entries
        load_matrix(SAT_MIN, SAT_MAX, SAT_MAX, SAT_MIN);
        send_item(KIND_PIX2WLD, SAT_MAX, SAT_MAX);
        send_item(KIND_WLD2PIX, SAT_MIN, 64'sd3);
        send_item(KIND_WLD2PIX, 64'sd0, 64'sd0);
        drain();

        // random settings, with a stretch of no idling in the middle
        for (int ph = 0; ph < 12; ph++)
        begin
            if (ph == 3)
                load_matrix(64'sd0, 64'sd0, 64'sd0, 64'sd0);
            else
                load_matrix(pick_entry(), pick_entry(), pick_entry(), pick_entry());
            load_refs();
            no_idle = (ph == 6);
            random_items(115);
            drain();
        end
        no_idle = 1'b0;

        $display("Sent %0d items over 18 settings; %0d results checked, %0d singular.",
                 sent, sb.checked, sb.singular_seen);
        $display("Covered both directions, extreme entries, saturation and singular cases.");
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // watchdog
    initial
    begin
        #4000000;
        $display("Timeout with %0d results still pending", sb.pending.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
